// ===== hw/rtl/ccp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_pkg
// Types, constants and helper functions shared by the container parser.
// ----------------------------------------------------------------------------
package ccp_pkg;

	localparam logic [31:0] MAGIC_WORD   = 32'h1221_3443;
	localparam logic [31:0] TAG_WORD     = 32'h2332_4554;
	localparam logic [31:0] MIN_FILE_LEN = 32'd17;
	localparam logic [19:0] MAX_RECORDS  = 20'd1000000;
	localparam logic [7:0]  MAX_NAME_LEN = 8'd255;
	localparam logic [7:0]  CH_PERCENT   = 8'h25;

	// record header sizes past the tag offset
	localparam logic [32:0] HDR_LEN      = 33'd12;
	localparam logic [32:0] HDR_NUL_LEN  = 33'd13;
	localparam logic [32:0] TAG_LEN      = 33'd4;

	// group queue
	localparam int GQ_DEPTH = 4;
	localparam int GQ_AW    = $clog2(GQ_DEPTH);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_MAGIC,
		PH_TAG,
		PH_NEXT,
		PH_NLEN,
		PH_NAME,
		PH_NUL,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_DESC = 2'd1,
		KIND_OK   = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ERR_SHORT     = 4'd0,
		ERR_MAGIC     = 4'd1,
		ERR_TAG       = 4'd2,
		ERR_TRUNCATED = 4'd3,
		ERR_NAMELEN   = 4'd4,
		ERR_NEXTOFF   = 4'd5,
		ERR_NONUL     = 4'd6,
		ERR_NEGSIZE   = 4'd7,
		ERR_TOOMANY   = 4'd8
	} err_t;

	// all results caused by one input byte
	typedef struct packed {
		logic [1:0]  cnt;       // number of results, 1 to 3
		logic        is_char;
		logic        esc;       // name byte goes out as %XX
		logic        has_desc;
		logic        has_end;
		logic        end_err;
		err_t        err;
		logic [7:0]  ch;
		logic [19:0] idx;
		logic [31:0] roff;
		logic [31:0] doff;
		logic [31:0] dsz;
	} grp_t;

	function automatic logic is_safe(input logic [7:0] c);
		logic ok;
		ok = (c > 8'h20) && (c < 8'h7f);
		ok = ok && (c != 8'h25) && (c != 8'h2f) && (c != 8'h5c) && (c != 8'h3a);
		ok = ok && (c != 8'h2a) && (c != 8'h3f) && (c != 8'h22) && (c != 8'h3c);
		ok = ok && (c != 8'h3e) && (c != 8'h7c);
		return ok;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'd0, v};
		end else begin
			r = 8'h41 + {4'd0, v} - 8'd10;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ccp_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_parser
// Input register and record-chain walker; emits at most one result group per byte.
// ----------------------------------------------------------------------------
module ccp_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [7:0]           s_tdata,
	input  wire  [0:0]           s_tuser,
	input  wire  [31:0]          total_size,
	input  wire                  gq_full,
	output logic                 gq_push,
	output ccp_pkg::grp_t        gq_grp
);
	import ccp_pkg::*;

	typedef struct packed {
		logic fail;
		err_t code;
		logic ok;
		logic chr;
		logic desc;
	} ev_t;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        adv;

	// walker state
	phase_t      phase_q;
	logic [7:0]  fcnt_q;
	logic [31:0] shift_q;
	logic [31:0] pos_q;
	logic [31:0] rstart_q;
	logic [31:0] next_q;
	logic [7:0]  nlen_q;
	logic [19:0] rcount_q;
	logic [32:0] doff_q;

	// effective state after a restart
	phase_t      ph_e;
	logic [7:0]  fcnt_e;
	logic [31:0] shift_e;
	logic [31:0] pos_e;
	logic [31:0] rstart_e;
	logic [31:0] next_e;
	logic [7:0]  nlen_e;
	logic [19:0] rcount_e;

	logic [31:0] shift_new;
	logic        word_done;
	logic [31:0] pos_n;
	logic [7:0]  fcnt_n;
	logic [19:0] rc_inc;
	logic [19:0] rc_sel;
	logic [32:0] doff_c;
	logic        short_f;
	logic        tag_trunc;
	logic        nl_bad;
	logic        next_bad;
	logic        nl_trunc;
	logic        next_lt_doff;
	logic        dsz_zero;
	logic        er_done;
	logic        er_many;
	logic        er_trunc;
	logic        endrec;
	ev_t         ev;

	phase_t      phase_d;
	logic [7:0]  fcnt_d;
	logic [31:0] shift_d;
	logic [31:0] pos_d;
	logic [31:0] rstart_d;
	logic [31:0] next_d;
	logic [7:0]  nlen_d;
	logic [19:0] rcount_d;
	logic [32:0] doff_d;

	assign adv      = valid_s1 && !gq_full;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser[0];
		end
	end

	// restart view and shared datapath
	always_comb begin
		ph_e     = first_s1 ? PH_MAGIC : phase_q;
		fcnt_e   = first_s1 ? 8'd0 : fcnt_q;
		shift_e  = first_s1 ? 32'd0 : shift_q;
		pos_e    = first_s1 ? 32'd0 : pos_q;
		rstart_e = first_s1 ? 32'd4 : rstart_q;
		next_e   = first_s1 ? 32'd0 : next_q;
		nlen_e   = first_s1 ? 8'd0 : nlen_q;
		rcount_e = first_s1 ? 20'd0 : rcount_q;

		shift_new = shift_e | ({24'd0, byte_s1} << {fcnt_e[1:0], 3'b000});
		word_done = (fcnt_e[1:0] == 2'd3);
		pos_n     = pos_e + 32'd1;
		fcnt_n    = fcnt_e + 8'd1;
		rc_inc    = rcount_e + 20'd1;
		rc_sel    = (ph_e == PH_NUL) ? rc_inc : rcount_e;

		short_f   = first_s1 && (total_size < MIN_FILE_LEN);
		tag_trunc = ({1'b0, rstart_e} + HDR_LEN) > {1'b0, total_size};
		nl_bad    = (shift_new > {24'd0, MAX_NAME_LEN}) || (shift_new == 32'd0);
		next_bad  = next_e[31] || (next_e < rstart_e) || (next_e > total_size);
		doff_c    = {1'b0, rstart_e} + HDR_NUL_LEN + {25'd0, shift_new[7:0]};
		nl_trunc  = doff_c > {1'b0, total_size};
		next_lt_doff = {1'b0, next_e} < doff_q;
		dsz_zero  = ({1'b0, next_e} == doff_q);

		// checks at the end of a record, against the following record start
		er_done   = next_e >= total_size;
		er_many   = rc_sel >= MAX_RECORDS;
		er_trunc  = ({1'b0, next_e} + TAG_LEN) > {1'b0, total_size};
	end

	// event decision
	always_comb begin
		ev     = '0;
		ev.code = ERR_SHORT;
		endrec = 1'b0;
		if (short_f) begin
			ev.fail = 1'b1;
			ev.code = ERR_SHORT;
		end else begin
			unique case (ph_e)
				PH_MAGIC: begin
					if (word_done && shift_new != MAGIC_WORD) begin
						ev.fail = 1'b1;
						ev.code = ERR_MAGIC;
					end
				end
				PH_TAG: begin
					if (word_done) begin
						priority if (shift_new == 32'd0) begin
							if (rcount_e == 20'd0) begin
								ev.fail = 1'b1;
								ev.code = ERR_TAG;
							end else begin
								ev.ok = 1'b1;
							end
						end else if (shift_new != TAG_WORD) begin
							ev.fail = 1'b1;
							ev.code = ERR_TAG;
						end else if (tag_trunc) begin
							ev.fail = 1'b1;
							ev.code = ERR_TRUNCATED;
						end
					end
				end
				PH_NLEN: begin
					if (word_done) begin
						priority if (nl_bad) begin
							ev.fail = 1'b1;
							ev.code = ERR_NAMELEN;
						end else if (next_bad) begin
							ev.fail = 1'b1;
							ev.code = ERR_NEXTOFF;
						end else if (nl_trunc) begin
							ev.fail = 1'b1;
							ev.code = ERR_TRUNCATED;
						end
					end
				end
				PH_NAME: begin
					ev.chr = 1'b1;
				end
				PH_NUL: begin
					priority if (byte_s1 != 8'd0) begin
						ev.fail = 1'b1;
						ev.code = ERR_NONUL;
					end else if (next_lt_doff) begin
						ev.fail = 1'b1;
						ev.code = ERR_NEGSIZE;
					end else begin
						ev.desc = 1'b1;
						endrec  = dsz_zero;
					end
				end
				PH_PAYLOAD: begin
					endrec = (pos_n == next_e);
				end
				default: ;
			endcase
			if (endrec) begin
				priority if (er_done) begin
					ev.ok = 1'b1;
				end else if (er_many) begin
					ev.fail = 1'b1;
					ev.code = ERR_TOOMANY;
				end else if (er_trunc) begin
					ev.fail = 1'b1;
					ev.code = ERR_TRUNCATED;
				end
			end
		end
	end

	// next state
	always_comb begin
		phase_d  = ph_e;
		fcnt_d   = fcnt_e;
		shift_d  = shift_e;
		pos_d    = pos_e;
		rstart_d = rstart_e;
		next_d   = next_e;
		nlen_d   = nlen_e;
		rcount_d = rcount_e;
		doff_d   = doff_q;
		if (short_f) begin
			phase_d = PH_DONE;
		end else if (ph_e != PH_IDLE && ph_e != PH_DONE) begin
			pos_d = pos_n;
			unique case (ph_e)
				PH_MAGIC, PH_TAG, PH_NEXT, PH_NLEN: begin
					fcnt_d  = fcnt_n;
					shift_d = shift_new;
					if (word_done) begin
						fcnt_d  = 8'd0;
						shift_d = 32'd0;
						unique case (ph_e)
							PH_MAGIC: begin
								rstart_d = 32'd4;
								phase_d  = PH_TAG;
							end
							PH_TAG:   phase_d = PH_NEXT;
							PH_NEXT: begin
								next_d  = shift_new;
								phase_d = PH_NLEN;
							end
							default: begin
								shift_d = shift_new;
								nlen_d  = shift_new[7:0];
								doff_d  = doff_c;
								phase_d = PH_NAME;
							end
						endcase
					end
				end
				PH_NAME: begin
					fcnt_d = fcnt_n;
					if (fcnt_n >= nlen_e) begin
						phase_d = PH_NUL;
					end
				end
				PH_NUL: begin
					rcount_d = rc_inc;
					phase_d  = PH_PAYLOAD;
				end
				default: ;
			endcase
			if (endrec) begin
				rstart_d = next_e;
				phase_d  = PH_TAG;
				fcnt_d   = 8'd0;
				shift_d  = 32'd0;
			end
			if (ev.fail || ev.ok) begin
				phase_d = PH_DONE;
			end
		end
	end

	// result group
	always_comb begin
		gq_grp          = '0;
		gq_grp.is_char  = ev.chr;
		gq_grp.esc      = !is_safe(byte_s1);
		gq_grp.ch       = byte_s1;
		gq_grp.has_desc = ev.desc;
		gq_grp.idx      = rcount_e;
		gq_grp.roff     = rstart_e;
		gq_grp.doff     = doff_q[31:0];
		gq_grp.dsz      = next_e - doff_q[31:0];
		gq_grp.has_end  = ev.fail || ev.ok;
		gq_grp.end_err  = ev.fail;
		gq_grp.err      = ev.code;
		if (ev.chr) begin
			gq_grp.cnt = gq_grp.esc ? 2'd3 : 2'd1;
		end else begin
			gq_grp.cnt = {1'b0, ev.desc} + {1'b0, gq_grp.has_end};
		end
		gq_push = adv && (ev.chr || ev.desc || gq_grp.has_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			fcnt_q   <= 8'd0;
			shift_q  <= 32'd0;
			pos_q    <= 32'd0;
			rstart_q <= 32'd4;
			next_q   <= 32'd0;
			nlen_q   <= 8'd0;
			rcount_q <= 20'd0;
		end else if (adv) begin
			phase_q  <= phase_d;
			fcnt_q   <= fcnt_d;
			shift_q  <= shift_d;
			pos_q    <= pos_d;
			rstart_q <= rstart_d;
			next_q   <= next_d;
			nlen_q   <= nlen_d;
			rcount_q <= rcount_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			doff_q <= doff_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ccp_group_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_group_fifo
// Small queue of result groups between the walker and the output side.
// ----------------------------------------------------------------------------
module ccp_group_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  ccp_pkg::grp_t        push_grp,
	input  wire                  pop,
	output ccp_pkg::grp_t        head,
	output logic                 not_empty,
	output logic                 full
);
	import ccp_pkg::*;

	grp_t             mem_q [GQ_DEPTH];
	logic [GQ_AW-1:0] wr_ptr_q;
	logic [GQ_AW-1:0] rd_ptr_q;
	logic [GQ_AW:0]   count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == (GQ_AW+1)'(GQ_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + GQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + GQ_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (GQ_AW+1)'(1);
				2'b01:   count_q <= count_q - (GQ_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ccp_unpack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_unpack
// Serializes the head result group into single result transfers.
// ----------------------------------------------------------------------------
module ccp_unpack (
	input  wire                  clk,
	input  wire                  arst_n,
	input  ccp_pkg::grp_t        head,
	input  wire                  not_empty,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [127:0]         m_tdata,   // name_char, record_index, record_offset,
	                                        // data_offset, data_size, error_code
	output logic [1:0]           m_tuser,   // kind
	output logic                 m_tlast
);
	import ccp_pkg::*;

	logic [1:0]  sub_q;
	logic        grp_end;
	logic        xfer;
	kind_t       kind;
	logic [7:0]  name_char;
	logic [19:0] idx;
	logic [31:0] roff;
	logic [31:0] doff;
	logic [31:0] dsz;
	err_t        err;

	assign m_tvalid = not_empty;
	assign xfer     = m_tvalid && m_tready;
	assign grp_end  = (sub_q == head.cnt - 2'd1);
	assign pop      = xfer && grp_end;
	assign m_tlast  = grp_end;

	always_comb begin
		kind      = KIND_CHAR;
		name_char = 8'd0;
		idx       = 20'd0;
		roff      = 32'd0;
		doff      = 32'd0;
		dsz       = 32'd0;
		err       = ERR_SHORT;
		if (head.is_char) begin
			if (!head.esc) begin
				name_char = head.ch;
			end else begin
				unique case (sub_q)
					2'd0:    name_char = CH_PERCENT;
					2'd1:    name_char = hex_digit(head.ch[7:4]);
					default: name_char = hex_digit(head.ch[3:0]);
				endcase
			end
		end else if (head.has_desc && sub_q == 2'd0) begin
			kind = KIND_DESC;
			idx  = head.idx;
			roff = head.roff;
			doff = head.doff;
			dsz  = head.dsz;
		end else if (head.end_err) begin
			kind = KIND_ERR;
			err  = head.err;
		end else begin
			kind = KIND_OK;
		end
	end

	assign m_tdata = {err, dsz, doff, roff, idx, name_char};
	assign m_tuser = kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 2'd0;
		end else if (xfer) begin
			sub_q <= grp_end ? 2'd0 : sub_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/record_chain_container_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// record_chain_container_parser
// Walks a record-chain container byte stream and emits escaped names,
// record descriptors and a final status.
// ----------------------------------------------------------------------------
// The first result of a byte passes the input register, then the
//   result-group queue, before it is offered.
// Throughput: 1 byte per cycle while the group queue is not full; an
//   escaped name byte gives 3 results; a 4-group queue absorbs such bursts.
// Reset: arst_n clears the walker to idle (waiting for a first byte), the
//   queue to empty and total_size to zero.
module record_chain_container_parser (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           cfg_valid,
	output logic          cfg_ready,
	input  wire  [31:0]   cfg_data,     // total_size
	input  wire           s_tvalid,
	output logic          s_tready,
	input  wire  [7:0]    s_tdata,      // data_byte
	input  wire  [0:0]    s_tuser,      // first
	output logic          m_tvalid,
	input  wire           m_tready,
	output logic [127:0]  m_tdata,      // name_char, record_index, record_offset,
	                                    // data_offset, data_size, error_code
	output logic [1:0]    m_tuser,      // kind
	output logic          m_tlast       // last
);
	import ccp_pkg::*;

	logic [31:0] total_size_q;
	logic        gq_push;
	logic        gq_pop;
	logic        gq_full;
	logic        gq_not_empty;
	grp_t        gq_in;
	grp_t        gq_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_size_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			total_size_q <= cfg_data;
		end
	end

	ccp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.total_size (total_size_q),
		.gq_full    (gq_full),
		.gq_push    (gq_push),
		.gq_grp     (gq_in)
	);

	ccp_group_fifo u_gq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (gq_push),
		.push_grp  (gq_in),
		.pop       (gq_pop),
		.head      (gq_head),
		.not_empty (gq_not_empty),
		.full      (gq_full)
	);

	ccp_unpack u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (gq_head),
		.not_empty (gq_not_empty),
		.pop       (gq_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire
